>>> hdl/spg_pkg.sv
// Types and constants shared by the servo pulse generator.
package spg_pkg;

   // Request kinds
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   // Key bytes
   localparam logic [7:0] KEY_MIN   = 8'h31;  // '1'
   localparam logic [7:0] KEY_MID   = 8'h32;  // '2'
   localparam logic [7:0] KEY_MAX   = 8'h33;  // '3'
   localparam logic [7:0] KEY_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] KEY_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] KEY_REPORT = 8'h72; // 'r'

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_PRELOAD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MIN      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MID      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MAX      = 2'd3;

   // Reset values
   localparam logic [7:0] RST_PERIOD_PRELOAD = 8'd30;
   localparam logic [7:0] RST_WIDTH_MIN      = 8'd31;
   localparam logic [7:0] RST_WIDTH_MID      = 8'd93;
   localparam logic [7:0] RST_WIDTH_MAX      = 8'd155;

   // Width of the overflow count
   localparam int unsigned OVF_W = 3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic       pulse_level;
      logic [7:0] current_width;
      logic       report;
   } rsp_type;

endpackage

>>> hdl/servo_pulse_generator.sv
// Servo pulse generator: tick counter, pulse timing and key width control.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  spg_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  spg_pkg::rsp_type
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// State updates at the accepting edge, which also registers the result for rsp;
// one request per cycle while req_stall is low.
// The result side has an output register plus one skid entry, so a request is
// still taken while one result waits; req_stall rises only when both are full.
// Reset is synchronous: width 93, pulse low, counters clear, registers default.
module servo_pulse_generator #(
   parameter int unsigned OVERFLOWS_PER_PERIOD = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  spg_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output spg_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [spg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata
);

   localparam logic [spg_pkg::OVF_W-1:0] OVF_RELOAD =
      spg_pkg::OVF_W'(OVERFLOWS_PER_PERIOD - 1);
   localparam logic [spg_pkg::OVF_W-1:0] OVF_START =
      spg_pkg::OVF_W'(OVERFLOWS_PER_PERIOD);

   logic [7:0] period_preload_ff;
   logic [7:0] width_min_ff;
   logic [7:0] width_mid_ff;
   logic [7:0] width_max_ff;

   logic [7:0]                  tick_ff, tick_in;
   logic [spg_pkg::OVF_W-1:0]   ovf_ff, ovf_in;
   logic                        active_ff, active_in;
   logic [7:0]                  width_ff, width_in;
   logic                        report_in;

   logic                        out_valid_ff, skid_valid_ff;
   spg_pkg::rsp_type            out_data_ff, skid_data_ff;
   spg_pkg::rsp_type            result;

   logic                        req_take;
   logic                        out_free;
   logic [7:0]                  tick_inc;
   logic [spg_pkg::OVF_W-1:0]   ovf_inc;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_preload_ff <= spg_pkg::RST_PERIOD_PRELOAD;
         width_min_ff      <= spg_pkg::RST_WIDTH_MIN;
         width_mid_ff      <= spg_pkg::RST_WIDTH_MID;
         width_max_ff      <= spg_pkg::RST_WIDTH_MAX;
      end else if (csr_we) begin
         case (csr_index)
            spg_pkg::CSR_PERIOD_PRELOAD: period_preload_ff <= csr_wdata;
            spg_pkg::CSR_WIDTH_MIN:      width_min_ff      <= csr_wdata;
            spg_pkg::CSR_WIDTH_MID:      width_mid_ff      <= csr_wdata;
            spg_pkg::CSR_WIDTH_MAX:      width_max_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign tick_inc = tick_ff + 8'd1;
   assign ovf_inc  = ovf_ff + spg_pkg::OVF_W'(1);

   // Advance the timer or apply a key, then check for pulse end
   always_comb begin
      tick_in   = tick_ff;
      ovf_in    = ovf_ff;
      active_in = active_ff;
      width_in  = width_ff;
      report_in = 1'b0;
      if (req_data.cmd == spg_pkg::CMD_TICK) begin
         tick_in = tick_inc;
         if (tick_inc == 8'd0) begin
            ovf_in = ovf_inc;
            if (ovf_inc == OVF_RELOAD) begin
               tick_in = period_preload_ff;
            end
            if (ovf_inc == OVF_START) begin
               active_in = 1'b1;
               ovf_in    = '0;
            end
         end
      end else begin
         case (req_data.key_code)
            spg_pkg::KEY_MIN: width_in = width_min_ff;
            spg_pkg::KEY_MID: width_in = width_mid_ff;
            spg_pkg::KEY_MAX: width_in = width_max_ff;
            spg_pkg::KEY_PLUS: begin
               if (width_ff >= width_max_ff) width_in = width_max_ff;
               else width_in = width_ff + 8'd1;
            end
            spg_pkg::KEY_MINUS: begin
               if (width_ff <= width_min_ff) width_in = width_min_ff;
               else width_in = width_ff - 8'd1;
            end
            spg_pkg::KEY_REPORT: report_in = 1'b1;
            default: ;
         endcase
      end
      if (active_in && (tick_in > width_in)) begin
         active_in = 1'b0;
      end
      result.pulse_level   = active_in;
      result.current_width = width_in;
      result.report        = report_in;
   end

   // Update generator state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         ovf_ff    <= '0;
         active_ff <= 1'b0;
         width_ff  <= spg_pkg::RST_WIDTH_MID;
      end else if (req_take) begin
         tick_ff   <= tick_in;
         ovf_ff    <= ovf_in;
         active_ff <= active_in;
         width_ff  <= width_in;
      end
   end

   // Output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_take;
         end
      end else if (req_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Move payloads alongside the valid bits
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_take) begin
            out_data_ff <= result;
         end
      end else if (req_take) begin
         skid_data_ff <= result;
      end
   end

endmodule
